>>> design/table_permutation_prng_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the generator RTL.
// Both expect clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef TABLE_PERMUTATION_PRNG_UNIT_MACROS_SVH
`define TABLE_PERMUTATION_PRNG_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TPP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define TPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tpp_pkg.sv
// ---------------------------------------------------------------------------
// tpp_pkg
// Types, constants and helpers of the table permutation generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpp_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int FOLD_GROUPS = 8;
	localparam int GROUP_W     = $clog2(FOLD_GROUPS);
	localparam int WORD_W      = 32;
	localparam int ROT_W       = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] MIX_STEP  = 32'h06a0_dd9b;
	localparam logic [WORD_W-1:0] PERM_STEP = 32'h9e37_79b7;
	localparam logic [WORD_W-1:0] SEED_RST  = 32'h0000_0001;

	localparam logic [IDX_W-1:0] TAP_LO    = IDX_W'(6);
	localparam logic [IDX_W-1:0] TAP_HI    = IDX_W'(7);
	localparam int               SHIFT_LO  = 6;
	localparam int               SHIFT_HI  = 7;
	localparam int               B_SHIFT   = 13;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(255);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W-1:0] STEP_ONE  = IDX_W'(1);

	// command codes
	localparam logic CMD_NEXT    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef struct packed {
		logic cmd;
		logic final_request;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] random_word;
		logic [WORD_W-1:0] constant_in_use;
	} out_t;

	// access request toward both tables
	typedef struct packed {
		logic [IDX_W-1:0]  m_raddr;
		logic              m_we;
		logic [IDX_W-1:0]  m_waddr;
		logic [WORD_W-1:0] m_wdata;
		logic [IDX_W-1:0]  l_raddr;
		logic              l_we;
		logic [IDX_W-1:0]  l_waddr;
		logic [WORD_W-1:0] l_wdata;
	} tbl_req_t;

	typedef enum logic [3:0] {
		S_FILL,
		S_IDLE,
		S_RD1,
		S_RD2,
		S_MIX1,
		S_MIX2,
		S_ROT,
		S_WR1,
		S_WR2,
		S_NEXT,
		S_RESEED,
		S_DRAIN
	} tpp_state_t;

	// rotate left; a zero amount passes the word through
	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
		input logic [ROT_W-1:0] r);
		logic [2*WORD_W-1:0] w;
		w = {v, v} << r;
		return w[2*WORD_W-1:WORD_W];
	endfunction

endpackage

>>> design/tpp_tables.sv
// ---------------------------------------------------------------------------
// tpp_tables
// Mixing table M and permutation table L: one write and one registered
// read port each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpp_tables (
	input  logic                        clk,
	input  tpp_pkg::tbl_req_t           req,
	output logic [tpp_pkg::WORD_W-1:0]  m_rdata,
	output logic [tpp_pkg::WORD_W-1:0]  l_rdata
);
	import tpp_pkg::*;

	logic [WORD_W-1:0] m_mem [TABLE_DEPTH];
	logic [WORD_W-1:0] l_mem [TABLE_DEPTH];

	// mixing table
	always_ff @(posedge clk) begin
		if (req.m_we) begin
			m_mem[req.m_waddr] <= req.m_wdata;
		end
		m_rdata <= m_mem[req.m_raddr];
	end

	// permutation table
	always_ff @(posedge clk) begin
		if (req.l_we) begin
			l_mem[req.l_waddr] <= req.l_wdata;
		end
		l_rdata <= l_mem[req.l_raddr];
	end

endmodule

>>> design/table_permutation_prng_unit.sv
// ---------------------------------------------------------------------------
// table_permutation_prng_unit
// Word generator over two 256-word tables with periodic reseeding.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (cmd, final_request)
//  out     | output    | out_valid/out_stall| out_data (random_word, constant_in_use)
//  cfg     | input     | cfg_we             | cfg_wdata (seed_value)
//
//  A next transaction runs S_RD1, S_RD2, S_MIX1, S_MIX2, S_ROT, S_WR1, S_WR2
//  and S_NEXT before the next accept; final_request skips the S_WR1/S_WR2
//  swap. The single table ports set this sequence. Every 255th step adds
//  a reseed sweep over M (one word a cycle). Restart and reset run the fill.
//  A new result waits in the rotate stage while out_stall holds the result
//  register; steps never overlap, so table accesses need no forwarding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "table_permutation_prng_unit_macros.svh"

module table_permutation_prng_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  tpp_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output tpp_pkg::out_t               out_data,
	input  logic                        cfg_we,
	input  logic [tpp_pkg::WORD_W-1:0]  cfg_wdata
);
	import tpp_pkg::*;

	tpp_state_t        state_q, state_nx;
	tbl_req_t          req;
	logic [WORD_W-1:0] m_rdata, l_rdata;

	logic [WORD_W-1:0] seed_q, const_q, a_q, b_q, cycle_q;
	logic [IDX_W-1:0]  d_q, step_q, cnt_q;
	logic [WORD_W-1:0] mfill_q, lfill_q, acc_q;
	logic [WORD_W-1:0] m6_q, li_q, o_q;
	logic              final_q;
	logic              rs_valid_s1;
	logic [IDX_W-1:0]  rs_idx_s1;
	logic              out_valid_q;
	out_t              out_q;

	logic              in_acc, out_ready, out_load;
	logic [WORD_W-1:0] o_mix, a_mix, b_mix, rot_word;
	logic [WORD_W-1:0] fold_word, fold_term, new_const, next_cycle;

	tpp_tables u_tables (
		.clk     (clk),
		.req     (req),
		.m_rdata (m_rdata),
		.l_rdata (l_rdata)
	);

	assign in_acc    = in_valid && !in_stall;
	assign out_ready = !out_valid_q || !out_stall;

	// step datapath
	assign o_mix    = (m6_q << SHIFT_LO) ^ (m_rdata << SHIFT_HI);
	assign a_mix    = (b_q ^ o_mix) ^ (const_q + a_q);
	assign b_mix    = (const_q + a_q) ^ (o_q + {{(WORD_W-IDX_W){1'b0}}, d_q});
	assign rot_word = rotl((b_q >> B_SHIFT) ^ a_q, b_q[ROT_W-1:0]);

	// reseed fold
	assign fold_word  = m_rdata ^ l_rdata;
	assign fold_term  = fold_word << rs_idx_s1[IDX_W-1 -: GROUP_W];
	assign new_const  = acc_q ^ fold_term;
	assign next_cycle = cycle_q + 1'b1;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_FILL:   if (cnt_q == LAST_IDX) state_nx = S_IDLE;
			S_IDLE: begin
				if (in_acc) begin
					state_nx = (in_data.cmd == CMD_RESTART) ? S_FILL : S_RD1;
				end
			end
			S_RD1:    state_nx = S_RD2;
			S_RD2:    state_nx = S_MIX1;
			S_MIX1:   state_nx = S_MIX2;
			S_MIX2:   state_nx = S_ROT;
			S_ROT: begin
				if (out_ready) begin
					state_nx = final_q ? S_NEXT : S_WR1;
				end
			end
			S_WR1:    state_nx = S_WR2;
			S_WR2:    state_nx = S_NEXT;
			S_NEXT:   state_nx = (step_q == STEP_ONE) ? S_RESEED : S_IDLE;
			S_RESEED: if (cnt_q == LAST_IDX) state_nx = S_DRAIN;
			S_DRAIN:  state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// outputs and table requests
	always_comb begin
		in_stall = (state_q != S_IDLE);
		out_load = 1'b0;
		req      = '0;
		unique case (state_q)
			S_FILL: begin
				req.m_we    = 1'b1;
				req.m_waddr = cnt_q;
				req.m_wdata = mfill_q;
				req.l_we    = 1'b1;
				req.l_waddr = cnt_q;
				req.l_wdata = lfill_q;
			end
			S_RD1: begin
				req.m_raddr = step_q + TAP_LO;
				req.l_raddr = step_q;
			end
			S_RD2: begin
				req.m_raddr = step_q + TAP_HI;
			end
			S_ROT: begin
				req.l_raddr = rot_word[IDX_W-1:0];
				out_load    = out_ready;
			end
			S_WR1: begin
				req.l_we    = 1'b1;
				req.l_waddr = step_q;
				req.l_wdata = l_rdata;
			end
			S_WR2: begin
				req.l_we    = 1'b1;
				req.l_waddr = d_q;
				req.l_wdata = li_q;
			end
			S_RESEED, S_DRAIN: begin
				req.m_raddr = cnt_q;
				req.l_raddr = cnt_q;
				req.m_we    = rs_valid_s1;
				req.m_waddr = rs_idx_s1;
				req.m_wdata = fold_word;
			end
			default: ;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			seed_q      <= SEED_RST;
			const_q     <= SEED_RST;
			a_q         <= SEED_RST;
			b_q         <= '0;
			d_q         <= '0;
			step_q      <= LAST_STEP;
			cycle_q     <= '0;
			cnt_q       <= '0;
			mfill_q     <= MIX_STEP;
			lfill_q     <= PERM_STEP;
			acc_q       <= '0;
			rs_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			rs_valid_s1 <= (state_q == S_RESEED);
			out_valid_q <= out_load || (out_valid_q && out_stall);

			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end

			// sweep counter wraps to zero at the end of each sweep
			if (state_q == S_FILL || state_q == S_RESEED) begin
				cnt_q <= cnt_q + 1'b1;
			end

			// fill values (k+1)*step, built by accumulation
			if (state_q == S_FILL) begin
				mfill_q <= mfill_q + MIX_STEP;
				lfill_q <= lfill_q + PERM_STEP;
			end

			// restart transaction
			if (in_acc && in_data.cmd == CMD_RESTART) begin
				const_q <= seed_q;
				a_q     <= seed_q;
				b_q     <= '0;
				d_q     <= '0;
				step_q  <= LAST_STEP;
				cycle_q <= '0;
				mfill_q <= MIX_STEP;
				lfill_q <= PERM_STEP;
			end

			// mixing steps
			if (state_q == S_MIX1) begin
				a_q <= a_mix;
			end
			if (state_q == S_MIX2) begin
				b_q <= b_mix;
			end
			if (state_q == S_ROT && out_ready) begin
				d_q <= rot_word[IDX_W-1:0];
			end
			if (state_q == S_NEXT) begin
				step_q <= step_q - 1'b1;
				acc_q  <= '0;
			end

			// reseed fold and new cycle constants
			if (state_q == S_RESEED && rs_valid_s1) begin
				acc_q <= new_const;
			end
			if (state_q == S_DRAIN) begin
				const_q <= new_const;
				a_q     <= new_const;
				cycle_q <= next_cycle;
				b_q     <= next_cycle;
				d_q     <= '0;
				step_q  <= LAST_STEP;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			final_q <= in_data.final_request;
		end
		if (state_q == S_RD2) begin
			m6_q <= m_rdata;
			li_q <= l_rdata;
		end
		if (state_q == S_MIX1) begin
			o_q <= o_mix;
		end
		rs_idx_s1 <= cnt_q;
		if (out_load) begin
			out_q.random_word     <= rot_word;
			out_q.constant_in_use <= const_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`TPP_ASSERT_NEXT(a_next_starts_read, in_acc && in_data.cmd == CMD_NEXT, state_q == S_RD1, "next transaction did not start table reads")
	`TPP_ASSERT_NOW(a_idle_step_nonzero, state_q == S_IDLE, step_q != '0, "step index zero while idle")
	`TPP_ASSERT_NOW(a_l_write_states, req.l_we, state_q == S_FILL || state_q == S_WR1 || state_q == S_WR2, "permutation table written outside fill or swap")
	`TPP_ASSERT_NEXT(a_reseed_entry, state_q == S_NEXT && step_q == STEP_ONE, state_q == S_RESEED && cnt_q == '0, "reseed sweep did not start at entry zero")

endmodule

>>> verif/table_permutation_prng_unit_tb.sv
// ---------------------------------------------------------------------------
// table_permutation_prng_unit_tb
// Self-checking bench for the table permutation word generator. A directed
// table covers reset values, seed extremes, final requests and restarts.
// Random phases follow under three idle patterns with a fresh seed each.
// A local copy of both tables and the mixing registers predicts every word,
// and each result transaction is checked against it in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_permutation_prng_unit_tb;

	import tpp_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 600;   // covers a fill plus a reseed sweep
	localparam int PHASE_ITEMS   = 290;
	localparam int PHASES        = 5;

	typedef enum logic {ROW_ITEM, ROW_SEED} row_kind_t;

	// value is the seed for ROW_SEED and the known constant for ROW_ITEM
	typedef struct packed {
		row_kind_t         kind;
		in_t               item;
		logic [WORD_W-1:0] value;
		logic              typed;
	} row_t;

	localparam int PLAN_ROWS = 21;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	in_t           in_data;
	logic          out_valid;
	logic          out_stall;
	out_t          out_data;
	logic          cfg_we;
	logic [WORD_W-1:0] cfg_wdata;

	// generator state as predicted
	logic [WORD_W-1:0] gen_perm [TABLE_DEPTH];
	logic [WORD_W-1:0] gen_mix [TABLE_DEPTH];
	logic [WORD_W-1:0] gen_seed;
	logic [WORD_W-1:0] gen_cons;
	logic [WORD_W-1:0] gen_a;
	logic [WORD_W-1:0] gen_b;
	logic [IDX_W-1:0]  gen_d;
	logic [IDX_W-1:0]  gen_step;
	logic [WORD_W-1:0] gen_cycle;

	out_t pending_words [$];
	int   error_count = 0;
	int   cycle_count = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   typed_pending = 1'b0;
	logic [WORD_W-1:0] typed_cons;

	row_t directed_plan [PLAN_ROWS] = '{
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'h0000_0001, 1'b1},
		'{ROW_ITEM, '{CMD_NEXT,    1'b1}, 32'h0000_0001, 1'b1},
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'h0000_0001, 1'b1},
		'{ROW_ITEM, '{CMD_RESTART, 1'b1}, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'h0000_0001, 1'b1},
		'{ROW_SEED, '{CMD_NEXT,    1'b0}, 32'hFFFF_FFFF, 1'b0},
		'{ROW_ITEM, '{CMD_RESTART, 1'b0}, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'hFFFF_FFFF, 1'b1},
		'{ROW_ITEM, '{CMD_NEXT,    1'b1}, 32'hFFFF_FFFF, 1'b1},
		'{ROW_ITEM, '{CMD_NEXT,    1'b1}, 32'hFFFF_FFFF, 1'b1},
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'hFFFF_FFFF, 1'b1},
		'{ROW_SEED, '{CMD_NEXT,    1'b0}, 32'h0000_0000, 1'b0},
		// new seed is not used until the next restart
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'hFFFF_FFFF, 1'b1},
		'{ROW_ITEM, '{CMD_RESTART, 1'b0}, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'h0000_0000, 1'b1},
		'{ROW_ITEM, '{CMD_NEXT,    1'b1}, 32'h0000_0000, 1'b1},
		'{ROW_SEED, '{CMD_NEXT,    1'b0}, 32'h8000_0001, 1'b0},
		'{ROW_ITEM, '{CMD_RESTART, 1'b1}, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '{CMD_RESTART, 1'b0}, 32'h0000_0000, 1'b0},
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'h8000_0001, 1'b1},
		'{ROW_ITEM, '{CMD_NEXT,    1'b0}, 32'h0000_0000, 1'b0}
	};

	table_permutation_prng_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Reload both tables from their formulas and restart from the seed
	function automatic void load_tables();
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			gen_mix[IDX_W'(k)]  = WORD_W'(k + 1) * MIX_STEP;
			gen_perm[IDX_W'(k)] = WORD_W'(k + 1) * PERM_STEP;
		end
		gen_cons  = gen_seed;
		gen_a     = gen_seed;
		gen_b     = '0;
		gen_d     = '0;
		gen_step  = LAST_STEP;
		gen_cycle = '0;
	endfunction

	// One accepted input transaction; returns 1 when it yields a word
	function automatic logic advance_generator(input in_t t, output out_t r);
		logic [IDX_W-1:0]  i;
		logic [WORD_W-1:0] o, v, c, held, acc, fold;
		logic [ROT_W-1:0]  amt;
		r = '0;
		if (t.cmd == CMD_RESTART) begin
			load_tables();
			return 1'b0;
		end
		i = gen_step;
		held = gen_cons;
		o = (gen_mix[IDX_W'(i + TAP_LO)] << SHIFT_LO) ^
			(gen_mix[IDX_W'(i + TAP_HI)] << SHIFT_HI);
		gen_a = (gen_b ^ o) ^ (held + gen_a);
		gen_b = (held + gen_a) ^ (o + WORD_W'(gen_d));
		v = (gen_b >> B_SHIFT) ^ gen_a;
		amt = gen_b[ROT_W-1:0];
		c = (amt == '0) ? v : ((v << amt) | (v >> (WORD_W - amt)));
		gen_d = c[IDX_W-1:0];
		// final request skips the permutation swap only
		if (!t.final_request) begin
			{gen_perm[i], gen_perm[gen_d]} = {gen_perm[gen_d], gen_perm[i]};
		end
		r.random_word = c;
		r.constant_in_use = held;
		gen_step = i - STEP_ONE;
		// end of a 255-step cycle: fold M ^ L into a new constant
		if (gen_step == '0) begin
			acc = '0;
			for (int k = 0; k < TABLE_DEPTH; k++)
				gen_mix[IDX_W'(k)] = gen_mix[IDX_W'(k)] ^ gen_perm[IDX_W'(k)];
			for (int g = 0; g < FOLD_GROUPS; g++) begin
				fold = '0;
				for (int k = 0; k < TABLE_DEPTH / FOLD_GROUPS; k++)
					fold = fold ^ gen_mix[IDX_W'(g * (TABLE_DEPTH / FOLD_GROUPS) + k)];
				acc = acc ^ (fold << g);
			end
			gen_cons  = acc;
			gen_cycle = gen_cycle + 1;
			gen_a     = acc;
			gen_b     = gen_cycle;
			gen_d     = '0;
			gen_step  = LAST_STEP;
		end
		return 1'b1;
	endfunction

	function automatic void note_failure(input string text);
		error_count++;
		if (error_count <= 10)
			$display("%t: %s", $realtime, text);
	endfunction

	// Watch both channels: predict on input accept, check on output accept
	always @(posedge clk) begin : watch_ports
		out_t want;
		if (arst_n && in_valid && !in_stall) begin
			if (advance_generator(in_data, want)) begin
				if (typed_pending) begin
					want.constant_in_use = typed_cons;
					typed_pending = 1'b0;
				end
				pending_words.push_back(want);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				note_failure($sformatf("unexpected result word=%h const=%h",
					out_data.random_word, out_data.constant_in_use));
			end else begin
				want = pending_words.pop_front();
				if (out_data.random_word !== want.random_word ||
					out_data.constant_in_use !== want.constant_in_use) begin
					note_failure($sformatf("word exp %h got %h, const exp %h got %h",
						want.random_word, out_data.random_word,
						want.constant_in_use, out_data.constant_in_use));
				end
			end
		end
	end

	// Receiver backpressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one input transaction and hold it until accepted
	task automatic send_item(input in_t item, input bit typed,
		input logic [WORD_W-1:0] typed_value);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		typed_pending = typed;
		typed_cons = typed_value;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// Seed write with the block idle; the settle wait covers a fill or reseed
	task automatic load_seed(input logic [WORD_W-1:0] value);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		gen_seed = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		in_t item;
		logic [WORD_W-1:0] value;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		gen_seed  = SEED_RST;
		load_tables();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_plan[r]) begin
			if (directed_plan[r].kind == ROW_SEED)
				load_seed(directed_plan[r].value);
			else
				send_item(directed_plan[r].item, directed_plan[r].typed,
					directed_plan[r].value);
		end

		// random phases, each with its own seed and one of three idle patterns
		for (int ph = 0; ph < PHASES; ph++) begin
			value = $urandom();
			if (ph == 0)
				value = '0;
			if (ph == PHASES - 1)
				value = '1;
			load_seed(value);
			send_idle_pct  = (ph < 2) ? 22 : (ph < 4) ? 71 : 0;
			recv_stall_pct = (ph < 2) ? 71 : (ph < 4) ? 22 : 0;
			item.cmd = CMD_RESTART;
			item.final_request = 1'($urandom_range(1));
			send_item(item, 1'b0, '0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender holds off until every word is back
				if (n == 100 || $urandom_range(199) == 0)
					hold_until_drained();
				item.cmd = ($urandom_range(399) == 0) ? CMD_RESTART : CMD_NEXT;
				item.final_request = ($urandom_range(3) == 0);
				send_item(item, 1'b0, '0);
			end
		end

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_words.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_words.size()));
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
